FILE: hdl/flat_json_object_parser_top_macros.svh
// Assertion macros for the flat JSON object parser.
`ifndef FLAT_JSON_OBJECT_PARSER_TOP_MACROS_SVH
`define FLAT_JSON_OBJECT_PARSER_TOP_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define FJOP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FJOP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hdl/fjop_pkg.sv
// Package for the flat JSON object parser: codes, phases, result record.
package fjop_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        EV_KEY_BYTE  = 3'd0,
        EV_KEY_DROP  = 3'd1,
        EV_STR_BYTE  = 3'd2,
        EV_STR_DONE  = 3'd3,
        EV_INT_DONE  = 3'd4,
        EV_CLOSED    = 3'd5,
        EV_STOPPED   = 3'd6,
        EV_TEXT_END  = 3'd7
    } event_t;

    typedef enum logic [8:0] {
        PH_PRE     = 9'b000000001,
        PH_TOP     = 9'b000000010,
        PH_KEY     = 9'b000000100,
        PH_COLON   = 9'b000001000,
        PH_VALWAIT = 9'b000010000,
        PH_STR     = 9'b000100000,
        PH_NUM     = 9'b001000000,
        PH_AFTER   = 9'b010000000,
        PH_DONE    = 9'b100000000
    } phase_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  ch;
        logic [31:0] num;
        logic        last;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

FILE: hdl/flat_json_object_parser_top.sv
// Flat JSON object parser: one text byte in, up to two result transactions out.
// An accepted byte waits in the input register until it is parsed; its results
// go into the result FIFO. Throughput: one byte per cycle, bounded by the
// result port, which moves one transaction per cycle through a small FIFO.
// Reset (aresetn low, synchronous) clears the parse state and empties the FIFO.
`include "flat_json_object_parser_top_macros.svh"

module flat_json_object_parser_top #(
    parameter int FifoDepth = fjop_pkg::FIFO_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_event_res,
    output logic [7:0]         m_char_out,
    output logic signed [31:0] m_number_value,
    output logic               m_last
);

    localparam int PTR_W = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
    localparam int CNT_W = $clog2(FifoDepth + 1);

    // input register
    logic                 in_valid_reg;
    logic [7:0]           byte_reg;

    // parse state
    fjop_pkg::phase_t     phase_reg, phase_next;
    logic [31:0]          mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic                 open_reg, open_next;

    // result FIFO
    fjop_pkg::result_t    fifo_reg [FifoDepth];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [PTR_W-1:0]     wr_ptr_inc;

    logic                 pop;
    logic                 proc_fire;
    logic [1:0]           n_res;
    fjop_pkg::result_t    r0, r1;
    fjop_pkg::result_t    head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FifoDepth - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop       = m_valid && m_ready;
    // room for two results, counting the transaction leaving this cycle
    assign proc_fire = in_valid_reg &&
                       ((cnt_reg - CNT_W'(pop)) <= CNT_W'(FifoDepth - 2));
    assign s_ready   = !in_valid_reg || proc_fire;

    // ------------------------------------------------------------------
    // parse step
    // ------------------------------------------------------------------
    logic [31:0]        num_val;
    logic [31:0]        mag_step;
    fjop_pkg::phase_t   eff_ph;
    logic               skip;
    logic               int_done;
    fjop_pkg::event_t   ea, eb;
    logic [7:0]         cha;
    logic [1:0]         sw_cnt;

    assign num_val  = neg_reg ? (32'd0 - mag_reg) : mag_reg;
    assign mag_step = {mag_reg[28:0], 3'b000} + {mag_reg[30:0], 1'b0}
                    + {28'd0, byte_reg[3:0]};

    always_comb begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        open_next  = open_reg;
        n_res      = 2'd0;
        r0         = '0;
        r1         = '0;
        eff_ph     = phase_reg;
        skip       = 1'b0;
        int_done   = 1'b0;
        ea         = fjop_pkg::EV_STOPPED;
        eb         = fjop_pkg::EV_STOPPED;
        cha        = 8'd0;
        sw_cnt     = 2'd0;

        if (byte_reg == fjop_pkg::CH_NUL) begin
            // end of text: close what is open, then report text end
            unique case (phase_reg)
                fjop_pkg::PH_STR: begin
                    r0.ev = fjop_pkg::EV_STR_DONE;
                    n_res = 2'd1;
                end
                fjop_pkg::PH_NUM: begin
                    r0.ev  = fjop_pkg::EV_INT_DONE;
                    r0.num = num_val;
                    n_res  = 2'd1;
                end
                fjop_pkg::PH_KEY, fjop_pkg::PH_COLON, fjop_pkg::PH_VALWAIT: begin
                    r0.ev = fjop_pkg::EV_KEY_DROP;
                    n_res = 2'd1;
                end
                default: ;
            endcase
            if (n_res == 2'd0) begin
                r0.ev = fjop_pkg::EV_TEXT_END;
            end else begin
                r1.ev = fjop_pkg::EV_TEXT_END;
            end
            n_res      = n_res + 2'd1;
            phase_next = fjop_pkg::PH_PRE;
            mag_next   = 32'd0;
            neg_next   = 1'b0;
            open_next  = 1'b0;
        end else begin
            if (phase_reg == fjop_pkg::PH_NUM) begin
                if (fjop_pkg::is_digit(byte_reg)) begin
                    if (open_reg) begin
                        mag_next = mag_step;
                    end
                    skip = 1'b1;
                end else if (byte_reg == fjop_pkg::CH_MINUS) begin
                    open_next = 1'b0;
                    skip      = 1'b1;
                end else begin
                    // integer ends; byte is reparsed as the one after a value
                    int_done  = 1'b1;
                    mag_next  = 32'd0;
                    neg_next  = 1'b0;
                    open_next = 1'b0;
                    eff_ph    = fjop_pkg::PH_AFTER;
                end
            end

            if (!skip) begin
                phase_next = eff_ph;
                unique case (eff_ph)
                    fjop_pkg::PH_PRE: begin
                        if (byte_reg == fjop_pkg::CH_LBRACE) begin
                            phase_next = fjop_pkg::PH_TOP;
                        end else if (!fjop_pkg::is_ws(byte_reg)) begin
                            ea         = fjop_pkg::EV_STOPPED;
                            sw_cnt     = 2'd1;
                            phase_next = fjop_pkg::PH_DONE;
                        end
                    end
                    fjop_pkg::PH_TOP, fjop_pkg::PH_AFTER: begin
                        priority if (fjop_pkg::is_ws(byte_reg)) begin
                            phase_next = eff_ph;
                        end else if (byte_reg == fjop_pkg::CH_COMMA &&
                                     eff_ph == fjop_pkg::PH_AFTER) begin
                            phase_next = fjop_pkg::PH_TOP;
                        end else if (byte_reg == fjop_pkg::CH_RBRACE) begin
                            ea         = fjop_pkg::EV_CLOSED;
                            sw_cnt     = 2'd1;
                            phase_next = fjop_pkg::PH_DONE;
                        end else if (byte_reg == fjop_pkg::CH_QUOTE) begin
                            phase_next = fjop_pkg::PH_KEY;
                        end else begin
                            ea         = fjop_pkg::EV_STOPPED;
                            sw_cnt     = 2'd1;
                            phase_next = fjop_pkg::PH_DONE;
                        end
                    end
                    fjop_pkg::PH_KEY: begin
                        if (byte_reg == fjop_pkg::CH_QUOTE) begin
                            phase_next = fjop_pkg::PH_COLON;
                        end else begin
                            ea     = fjop_pkg::EV_KEY_BYTE;
                            cha    = byte_reg;
                            sw_cnt = 2'd1;
                        end
                    end
                    fjop_pkg::PH_COLON: begin
                        if (byte_reg == fjop_pkg::CH_COLON) begin
                            phase_next = fjop_pkg::PH_VALWAIT;
                        end else if (!fjop_pkg::is_ws(byte_reg)) begin
                            ea         = fjop_pkg::EV_KEY_DROP;
                            eb         = fjop_pkg::EV_STOPPED;
                            sw_cnt     = 2'd2;
                            phase_next = fjop_pkg::PH_DONE;
                        end
                    end
                    fjop_pkg::PH_VALWAIT: begin
                        priority if (fjop_pkg::is_ws(byte_reg)) begin
                            phase_next = fjop_pkg::PH_VALWAIT;
                        end else if (byte_reg == fjop_pkg::CH_QUOTE) begin
                            phase_next = fjop_pkg::PH_STR;
                        end else if (fjop_pkg::is_digit(byte_reg)) begin
                            mag_next   = {28'd0, byte_reg[3:0]};
                            neg_next   = 1'b0;
                            open_next  = 1'b1;
                            phase_next = fjop_pkg::PH_NUM;
                        end else if (byte_reg == fjop_pkg::CH_MINUS) begin
                            mag_next   = 32'd0;
                            neg_next   = 1'b1;
                            open_next  = 1'b1;
                            phase_next = fjop_pkg::PH_NUM;
                        end else begin
                            ea         = fjop_pkg::EV_KEY_DROP;
                            eb         = fjop_pkg::EV_STOPPED;
                            sw_cnt     = 2'd2;
                            phase_next = fjop_pkg::PH_DONE;
                        end
                    end
                    fjop_pkg::PH_STR: begin
                        if (byte_reg == fjop_pkg::CH_QUOTE) begin
                            ea         = fjop_pkg::EV_STR_DONE;
                            sw_cnt     = 2'd1;
                            phase_next = fjop_pkg::PH_AFTER;
                        end else begin
                            ea     = fjop_pkg::EV_STR_BYTE;
                            cha    = byte_reg;
                            sw_cnt = 2'd1;
                        end
                    end
                    default: begin
                        phase_next = fjop_pkg::PH_DONE;
                    end
                endcase
            end

            // merge: an integer close comes first, then at most one more event
            if (int_done) begin
                r0.ev  = fjop_pkg::EV_INT_DONE;
                r0.num = num_val;
                r1.ev  = ea;
                r1.ch  = cha;
                n_res  = 2'd1 + sw_cnt;
            end else begin
                r0.ev  = ea;
                r0.ch  = cha;
                r1.ev  = eb;
                n_res  = sw_cnt;
            end
        end

        r0.last = (n_res == 2'd1);
        r1.last = 1'b1;
    end

    // ------------------------------------------------------------------
    // FIFO pointers
    // ------------------------------------------------------------------
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (proc_fire) begin
            unique case (n_res)
                2'd1:    wr_ptr_next = wr_ptr_inc;
                2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
                default: wr_ptr_next = wr_ptr_reg;
            endcase
            cnt_next = cnt_next + CNT_W'(n_res);
        end
        if (pop) begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            cnt_next    = cnt_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= fjop_pkg::PH_PRE;
            mag_reg      <= 32'd0;
            neg_reg      <= 1'b0;
            open_reg     <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire) begin
                phase_reg <= phase_next;
                mag_reg   <= mag_next;
                neg_reg   <= neg_next;
                open_reg  <= open_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_text_byte;
        end
        if (proc_fire && n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= r0;
        end
        if (proc_fire && n_res == 2'd2) begin
            fifo_reg[wr_ptr_inc] <= r1;
        end
    end

    assign head           = fifo_reg[rd_ptr_reg];
    assign m_valid        = (cnt_reg != '0);
    assign m_event_res    = head.ev;
    assign m_char_out     = head.ch;
    assign m_number_value = $signed(head.num);
    assign m_last         = head.last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    logic end_fire;
    logic done_fire;
    logic rearmed;

    assign end_fire  = proc_fire && (byte_reg == fjop_pkg::CH_NUL);
    assign done_fire = proc_fire && (phase_reg == fjop_pkg::PH_DONE) &&
                       (byte_reg != fjop_pkg::CH_NUL);
    assign rearmed   = (phase_reg == fjop_pkg::PH_PRE) && !open_reg && !neg_reg &&
                       (mag_reg == 32'd0);

    `FJOP_ASSERT(a_fifo_bound, (cnt_reg <= CNT_W'(FifoDepth)), "result FIFO overfilled")
    `FJOP_ASSERT(a_end_rearms, end_fire |=> rearmed, "text end did not rearm the parser")
    `FJOP_ASSERT(a_done_silent, done_fire |-> n_res == 2'd0, "result after close or stop")
    `FJOP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (!m_valid && s_ready), "pending after reset")

endmodule

FILE: tb/flat_json_object_parser_top_tb.sv
// Self-checking bench for the flat JSON object parser: random and directed texts vs a predictor.
module flat_json_object_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fjop_pkg::*;

    localparam int TEXT_TARGET    = 2000;
    localparam int MAX_GAP        = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_text_byte = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_event_res;
    logic [7:0]         m_char_out;
    logic signed [31:0] m_number_value;
    logic               m_last;

    flat_json_object_parser_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_char_out     (m_char_out),
        .m_number_value (m_number_value),
        .m_last         (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // stimulus and expectation stores
    logic [7:0] text_stream[$];
    logic [7:0] draft[$];
    result_t    expected_events[$];

    // predictor state
    phase_t      parse_st = PH_PRE;
    logic [31:0] num_mag = '0;
    logic        num_neg = 1'b0;
    logic        num_open = 1'b0;

    int bytes_sent = 0;
    int results_checked = 0;
    int texts_built = 0;
    int error_count = 0;
    int quiet_cycles = 0;
    int byte_gap = 0;
    int result_stall = 0;
    bit drive_steady = 1'b0;
    bit sink_steady = 1'b0;

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_decimal(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic result_t make_event(input event_t ev, input logic [7:0] ch,
                                           input logic [31:0] num);
        result_t r;
        r.ev   = ev;
        r.ch   = ch;
        r.num  = num;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] signed_number();
        return num_neg ? (32'd0 - num_mag) : num_mag;
    endfunction

    // Advance the parser by one text byte and queue the events it raises.
    task automatic parse_text_byte(input logic [7:0] c);
        result_t batch[$];
        phase_t  ph;
        bit      handled;
        ph = parse_st;
        handled = 1'b0;
        if (c == CH_NUL) begin
            case (ph)
                PH_STR: batch.push_back(make_event(EV_STR_DONE, '0, '0));
                PH_NUM: batch.push_back(make_event(EV_INT_DONE, '0, signed_number()));
                PH_KEY, PH_COLON, PH_VALWAIT: batch.push_back(make_event(EV_KEY_DROP, '0, '0));
                default: ;
            endcase
            batch.push_back(make_event(EV_TEXT_END, '0, '0));
            parse_st = PH_PRE;
            num_mag  = '0;
            num_neg  = 1'b0;
            num_open = 1'b0;
            handled  = 1'b1;
        end else if (ph == PH_NUM) begin
            if (is_decimal(c)) begin
                if (num_open)
                    num_mag = num_mag * 32'd10 + {24'd0, c - CH_ZERO};
                handled = 1'b1;
            end else if (c == CH_MINUS) begin
                num_open = 1'b0;
                handled = 1'b1;
            end else begin
                // integer ends; byte falls through as the one after a value
                batch.push_back(make_event(EV_INT_DONE, '0, signed_number()));
                num_mag  = '0;
                num_neg  = 1'b0;
                num_open = 1'b0;
                ph = PH_AFTER;
            end
        end
        if (!handled) begin
            case (ph)
                PH_PRE: begin
                    if (c == CH_LBRACE) begin
                        ph = PH_TOP;
                    end else if (!is_blank(c)) begin
                        batch.push_back(make_event(EV_STOPPED, '0, '0));
                        ph = PH_DONE;
                    end
                end
                PH_TOP, PH_AFTER: begin
                    if (is_blank(c)) begin
                    end else if (c == CH_COMMA && ph == PH_AFTER) begin
                        ph = PH_TOP;
                    end else if (c == CH_RBRACE) begin
                        batch.push_back(make_event(EV_CLOSED, '0, '0));
                        ph = PH_DONE;
                    end else if (c == CH_QUOTE) begin
                        ph = PH_KEY;
                    end else begin
                        batch.push_back(make_event(EV_STOPPED, '0, '0));
                        ph = PH_DONE;
                    end
                end
                PH_KEY: begin
                    if (c == CH_QUOTE)
                        ph = PH_COLON;
                    else
                        batch.push_back(make_event(EV_KEY_BYTE, c, '0));
                end
                PH_COLON: begin
                    if (is_blank(c)) begin
                    end else if (c == CH_COLON) begin
                        ph = PH_VALWAIT;
                    end else begin
                        batch.push_back(make_event(EV_KEY_DROP, '0, '0));
                        batch.push_back(make_event(EV_STOPPED, '0, '0));
                        ph = PH_DONE;
                    end
                end
                PH_VALWAIT: begin
                    if (is_blank(c)) begin
                    end else if (c == CH_QUOTE) begin
                        ph = PH_STR;
                    end else if (is_decimal(c)) begin
                        num_mag  = {24'd0, c - CH_ZERO};
                        num_neg  = 1'b0;
                        num_open = 1'b1;
                        ph = PH_NUM;
                    end else if (c == CH_MINUS) begin
                        num_mag  = '0;
                        num_neg  = 1'b1;
                        num_open = 1'b1;
                        ph = PH_NUM;
                    end else begin
                        batch.push_back(make_event(EV_KEY_DROP, '0, '0));
                        batch.push_back(make_event(EV_STOPPED, '0, '0));
                        ph = PH_DONE;
                    end
                end
                PH_STR: begin
                    if (c == CH_QUOTE) begin
                        batch.push_back(make_event(EV_STR_DONE, '0, '0));
                        ph = PH_AFTER;
                    end else begin
                        batch.push_back(make_event(EV_STR_BYTE, c, '0));
                    end
                end
                default: ph = PH_DONE;
            endcase
            parse_st = ph;
        end
        if (batch.size() != 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_events.push_back(batch[i]);
    endtask

    task automatic push_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            text_stream.push_back(s[i]);
    endtask

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 5))
            0: return CH_TAB;
            1: return 8'h0A;
            2: return 8'h0B;
            3: return 8'h0C;
            4: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic add_blanks();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) draft.push_back(random_blank());
    endtask

    // any byte that cannot close a quoted run or end the text
    function automatic logic [7:0] quoted_char();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        return (b == CH_QUOTE) ? 8'h23 : b;
    endfunction

    task automatic add_number();
        int ndig;
        if ($urandom_range(0, 2) == 0)
            draft.push_back(CH_MINUS);
        // mostly short; some long enough to wrap the 32-bit magnitude
        ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
        if (ndig == 0 && draft[draft.size() - 1] != CH_MINUS)
            ndig = 1;
        repeat (ndig) draft.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 5) == 0) begin
            draft.push_back(CH_MINUS);
            repeat ($urandom_range(0, 3)) draft.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    // One random text: mostly a well-formed object, some broken or pure noise.
    task automatic build_text();
        int kind;
        int pos;
        draft.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 10)) draft.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_blanks();
            draft.push_back(CH_LBRACE);
            repeat ($urandom_range(0, 4)) begin
                add_blanks();
                draft.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 4)) draft.push_back(quoted_char());
                draft.push_back(CH_QUOTE);
                add_blanks();
                draft.push_back(CH_COLON);
                add_blanks();
                if ($urandom_range(0, 1)) begin
                    draft.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 5)) draft.push_back(quoted_char());
                    draft.push_back(CH_QUOTE);
                end else begin
                    add_number();
                end
                add_blanks();
                if ($urandom_range(0, 3) != 0)
                    draft.push_back(CH_COMMA);
            end
            add_blanks();
            draft.push_back(CH_RBRACE);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) draft.push_back(8'($urandom_range(1, 255)));
            if (kind <= 3) begin
                pos = $urandom_range(0, draft.size() - 1);
                if ($urandom_range(0, 1))
                    draft[pos] = 8'($urandom_range(0, 255));
                else
                    draft = draft[0:pos];
            end
        end
        draft.push_back(CH_NUL);
        foreach (draft[i])
            text_stream.push_back(draft[i]);
        texts_built++;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    // input driver
    always @(posedge aclk) begin : drive_proc
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_text_byte(s_text_byte);
                bytes_sent++;
                if ($urandom_range(0, 63) == 0)
                    drive_steady = !drive_steady;
                byte_gap = drive_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!s_valid || s_ready) begin
                if (byte_gap > 0) begin
                    byte_gap--;
                    s_valid <= 1'b0;
                end else if (text_stream.size() != 0) begin
                    s_valid <= 1'b1;
                    s_text_byte <= text_stream.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : sink_proc
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result transaction, expected none, %s %0d char 0x%0h",
                             $time, "actual event", m_event_res, m_char_out);
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_res", want.ev, m_event_res);
                    check_field("char_out", want.ch, m_char_out);
                    check_field("number_value", want.num, m_number_value);
                    check_field("last", want.last, m_last);
                    results_checked++;
                end
                if ($urandom_range(0, 63) == 0)
                    sink_steady = !sink_steady;
                result_stall = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (result_stall > 0) begin
                result_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, expected_events.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        // key with 0xFF, double-minus integer, string value, comma
        push_chars(" {\"");
        text_stream.push_back(8'hFF);
        push_chars("\":-12-3,\"s\":\"x\"}");
        text_stream.push_back(CH_NUL);
        // text ends while a key waits for its value
        push_chars("{\"a\":");
        text_stream.push_back(CH_NUL);
        // junk before the brace
        push_chars("x");
        text_stream.push_back(CH_NUL);
        while (text_stream.size() < TEXT_TARGET)
            build_text();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (text_stream.size() == 0 && !s_valid);
        wait (expected_events.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d texts, %0d bytes in, %0d result transactions checked.",
                 texts_built + 3, bytes_sent, results_checked);
        $display("Mismatches: %0d", error_count);
        if (error_count == 0 && expected_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
